FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the event queue RTL.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every sampled edge.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/teoq_pkg.sv
// Package for the timestamp ordered event queue.
// Holds field widths, operation codes, sequencer states and the structs
// passed between the queue modules. Depends on nothing.
`default_nettype none

package teoq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int MAX_RESULTS  = 64;

  localparam int OP_W   = 2;
  localparam int PORT_W = 8;
  localparam int MSG_W  = 32;
  localparam int TIME_W = 32;
  localparam int FILL_W = 7;
  localparam int EMIT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_SEND  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } teoq_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FINISH,
    ST_REPLY
  } teoq_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [MSG_W-1:0]  message;
    logic [PORT_W-1:0] port;
    logic              off;
  } teoq_entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } teoq_mem_ctl_t;

  typedef struct packed {
    logic              has_event;
    logic [PORT_W-1:0] out_port;
    logic [MSG_W-1:0]  out_message;
    logic              status;
    logic [FILL_W-1:0] fill_count;
    logic              last;
  } teoq_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/teoq_if.sv
// Handshake channel interfaces of the event queue: one for input items,
// one for results. Both carry valid, ready and the payload fields.
// Depends on teoq_pkg.
`default_nettype none

interface teoq_in_if;
  import teoq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PORT_W-1:0] port;
  logic [MSG_W-1:0]  message;
  logic              off_event;
  logic [TIME_W-1:0] due_time;
  logic [TIME_W-1:0] now_tick;

  modport source (
    output valid, operation, port, message, off_event, due_time, now_tick,
    input  ready
  );
  modport sink (
    input  valid, operation, port, message, off_event, due_time, now_tick,
    output ready
  );
endinterface

interface teoq_out_if;
  import teoq_pkg::*;

  logic              valid;
  logic              ready;
  logic              has_event;
  logic [PORT_W-1:0] out_port;
  logic [MSG_W-1:0]  out_message;
  logic              status;
  logic [FILL_W-1:0] fill_count;
  logic              last;

  modport source (
    output valid, has_event, out_port, out_message, status, fill_count, last,
    input  ready
  );
  modport sink (
    input  valid, has_event, out_port, out_message, status, fill_count, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/teoq_mem.sv
// Event store of the queue: one write port and one registered read port.
// Entries are addressed as a circular buffer by the sequencer.
// Depends on teoq_pkg.
`default_nettype none

module teoq_mem #(
  parameter int CAPACITY = teoq_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  wire                        clk,
  input  wire teoq_pkg::teoq_mem_ctl_t ctl,
  input  wire [IDX_W-1:0]            waddr,
  input  wire [IDX_W-1:0]            raddr,
  input  wire teoq_pkg::teoq_entry_t wdata,
  output teoq_pkg::teoq_entry_t      rdata
);
  import teoq_pkg::*;

  teoq_entry_t mem [CAPACITY];
  teoq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a stalled sequencer keeps it.
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/teoq_out_reg.sv
// Output register of the event queue result channel.
// Holds one result until the receiver takes it; reports when a new one fits.
// Depends on teoq_pkg and teoq_if.
`default_nettype none

module teoq_out_reg (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  wire teoq_pkg::teoq_result_t result,
  output logic                        free,
  teoq_out_if.source                  out_ch
);
  import teoq_pkg::*;

  logic         valid_r;
  teoq_result_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= result;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.has_event   = res_r.has_event;
  assign out_ch.out_port    = res_r.out_port;
  assign out_ch.out_message = res_r.out_message;
  assign out_ch.status      = res_r.status;
  assign out_ch.fill_count  = res_r.fill_count;
  assign out_ch.last        = res_r.last;

endmodule

`default_nettype wire

FILE: rtl/core/teoq_ctrl.sv
// Sequencer of the event queue with its shared timestamp comparator.
// Walks the circular event store one entry at a time for sorted insert,
// tick release and flush. Depends on teoq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module teoq_ctrl #(
  parameter int CAPACITY = teoq_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [teoq_pkg::OP_W-1:0]    in_op,
  input  wire [teoq_pkg::PORT_W-1:0]  in_port,
  input  wire [teoq_pkg::MSG_W-1:0]   in_message,
  input  wire                         in_off,
  input  wire [teoq_pkg::TIME_W-1:0]  in_due,
  input  wire [teoq_pkg::TIME_W-1:0]  in_now,
  output teoq_pkg::teoq_mem_ctl_t     mem_ctl,
  output logic [IDX_W-1:0]            mem_waddr,
  output logic [IDX_W-1:0]            mem_raddr,
  output teoq_pkg::teoq_entry_t       mem_wdata,
  input  wire teoq_pkg::teoq_entry_t  mem_rdata,
  input  wire                         out_free,
  output logic                        out_push,
  output teoq_pkg::teoq_result_t      out_result
);
  import teoq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PTR_W = IDX_W + 1;

  teoq_state_t       state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  teoq_entry_t       ent_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  step_r;
  logic [EMIT_W-1:0] emit_r;
  logic              status_r;
  logic              pend_valid_r;
  logic [PORT_W-1:0] pend_port_r;
  logic [MSG_W-1:0]  pend_msg_r;
  logic [CNT_W-1:0]  pend_fill_r;

  logic              is_tick;
  logic [TIME_W-1:0] key;
  logic              later;
  logic              take;
  logic              stall;
  logic              scan_done;
  logic              queue_full;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [PTR_W-1:0] sum;
    sum = PTR_W'(base) + PTR_W'(off);
    if (sum >= PTR_W'(CAPACITY)) begin
      sum = sum - PTR_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ptr_prev(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  // One comparator serves both the insert walk and the tick release.
  assign is_tick    = (op_r == OP_TICK);
  assign key        = is_tick ? now_r : ent_r.due;
  assign later      = (mem_rdata.due > key);
  assign take       = is_tick ? !later : mem_rdata.off;
  assign stall      = take && pend_valid_r && !out_free;
  assign scan_done  = (step_r == count_r) || (emit_r == EMIT_W'(MAX_RESULTS));
  assign queue_full = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_SEND:           state_nxt = queue_full ? ST_REPLY : ST_INS_RD;
            OP_TICK, OP_FLUSH: state_nxt = ST_SCAN_RD;
            default:           state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_INS_RD:  state_nxt = (step_r == '0) ? ST_REPLY : ST_INS_EV;
      ST_INS_EV:  state_nxt = later ? ST_INS_RD : ST_REPLY;
      ST_SCAN_RD: state_nxt = scan_done ? ST_FINISH : ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!stall) begin
          state_nxt = (is_tick && later) ? ST_FINISH : ST_SCAN_RD;
        end
      end
      ST_FINISH, ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    mem_ctl    = '0;
    mem_waddr  = ptr_r;
    mem_raddr  = ptr_r;
    mem_wdata  = ent_r;
    out_push   = 1'b0;
    out_result = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_INS_RD: begin
        if (step_r == '0) begin
          mem_ctl.we = 1'b1;
        end else begin
          mem_ctl.re = 1'b1;
          mem_raddr  = ptr_prev(ptr_r);
        end
      end
      ST_INS_EV: begin
        // A later entry moves up one slot; otherwise the new event lands here.
        mem_ctl.we = 1'b1;
        mem_wdata  = later ? mem_rdata : ent_r;
      end
      ST_SCAN_RD: mem_ctl.re = !scan_done;
      ST_SCAN_EV: begin
        // A held event goes out once the next one proves it is not the final.
        if (take && pend_valid_r && out_free) begin
          out_push               = 1'b1;
          out_result.has_event   = 1'b1;
          out_result.out_port    = pend_port_r;
          out_result.out_message = pend_msg_r;
          out_result.fill_count  = FILL_W'(pend_fill_r);
        end
      end
      ST_FINISH: begin
        out_push               = out_free;
        out_result.has_event   = pend_valid_r;
        out_result.out_port    = pend_valid_r ? pend_port_r : '0;
        out_result.out_message = pend_valid_r ? pend_msg_r : '0;
        out_result.fill_count  = FILL_W'(count_r - step_r);
        out_result.last        = 1'b1;
      end
      ST_REPLY: begin
        out_push              = out_free;
        out_result.status     = status_r;
        out_result.fill_count = FILL_W'(count_r);
        out_result.last       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      emit_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r         <= in_op;
            ent_r        <= '{due: in_due, message: in_message, port: in_port,
                              off: in_off};
            now_r        <= in_now;
            status_r     <= (in_op == OP_SEND) && queue_full;
            emit_r       <= '0;
            pend_valid_r <= 1'b0;
            if (in_op == OP_SEND) begin
              step_r <= count_r;
              ptr_r  <= wrap_add(head_r, count_r);
            end else begin
              step_r <= '0;
              ptr_r  <= head_r;
            end
          end
        end
        ST_INS_RD: begin
          if (step_r == '0) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        ST_INS_EV: begin
          if (later) begin
            ptr_r  <= ptr_prev(ptr_r);
            step_r <= step_r - CNT_W'(1);
          end else begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        ST_SCAN_EV: begin
          if (!stall) begin
            if (take) begin
              pend_valid_r <= 1'b1;
              pend_port_r  <= mem_rdata.port;
              pend_msg_r   <= mem_rdata.message;
              pend_fill_r  <= count_r - step_r - CNT_W'(1);
              emit_r       <= emit_r + EMIT_W'(1);
            end
            if (!(is_tick && later)) begin
              step_r <= step_r + CNT_W'(1);
              ptr_r  <= ptr_next(ptr_r);
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            head_r       <= wrap_add(head_r, step_r);
            count_r      <= count_r - step_r;
            pend_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY),
                 "held count above capacity")
  `ASSERT_ALWAYS(a_emit_bound, clk, rst_n, emit_r <= EMIT_W'(MAX_RESULTS),
                 "result cap exceeded")
  `ASSERT_IMPLIES(a_idle_no_pend, clk, rst_n, state_r == ST_IDLE, !pend_valid_r,
                  "event left pending while idle")
  `ASSERT_IMPLIES(a_refuse_full, clk, rst_n, state_r == ST_REPLY && status_r, queue_full,
                  "send refused with room left")
  `ASSERT_NEXT(a_finish_drop, clk, rst_n, state_r == ST_FINISH && out_free,
               state_r == ST_IDLE && count_r == $past(count_r) - $past(step_r),
               "scan end did not drop the scanned events")

endmodule

`default_nettype wire

FILE: rtl/core/timestamp_ordered_event_queue.sv
// Timestamp ordered event queue: a bounded queue of events kept in
// ascending due-time order, equal due times in arrival order.
//
// Input channel in_ch: one transfer per item. operation selects send (insert
// port, message, off flag at due_time), tick (release every head event with
// due time at or below now_tick) or flush (empty the queue, returning only
// the off events). Result channel out_ch: each item yields one or more
// results; the final one carries last, fill_count gives the events held.
// A send to a full queue returns status 1 and changes nothing.
//
// Flow: the block takes one item at a time and is not ready until its
// final result is in the output register. All work goes through the single
// read port of the event store and one shared timestamp comparator; each
// visited entry passes a read state and then an evaluate state. A send walks
// the later events it moves, a tick the head events it examines, a flush
// every held event; a refused send or an unknown operation goes straight to
// its reply. Results wait in an output register; while the receiver stalls,
// the sequencer pauses at its next result. Reset empties the queue at once;
// the store needs no clearing pass.
// Depends on teoq_pkg, teoq_if, teoq_mem, teoq_out_reg and teoq_ctrl.
`default_nettype none

module timestamp_ordered_event_queue #(
  parameter int CAPACITY = teoq_pkg::CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  teoq_in_if.sink    in_ch,
  teoq_out_if.source out_ch
);
  import teoq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  teoq_mem_ctl_t    mem_ctl;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  teoq_entry_t      mem_wdata;
  teoq_entry_t      mem_rdata;
  logic             out_free;
  logic             out_push;
  teoq_result_t     out_result;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  teoq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_op      (in_ch.operation),
    .in_port    (in_ch.port),
    .in_message (in_ch.message),
    .in_off     (in_ch.off_event),
    .in_due     (in_ch.due_time),
    .in_now     (in_ch.now_tick),
    .mem_ctl    (mem_ctl),
    .mem_waddr  (mem_waddr),
    .mem_raddr  (mem_raddr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .out_free   (out_free),
    .out_push   (out_push),
    .out_result (out_result)
  );

  teoq_mem #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .raddr (mem_raddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  teoq_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (out_push),
    .result (out_result),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
